// ===== design/visible_rect_list_builder_core_defines.svh =====
// ----------------------------------------------------------------------------
// visible_rect_list_builder_core_defines
// assertion macros for the visible rectangle list builder
// ----------------------------------------------------------------------------
`ifndef VISIBLE_RECT_LIST_BUILDER_CORE_DEFINES_SVH
`define VISIBLE_RECT_LIST_BUILDER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define VRLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define VRLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vrlb_pkg.sv =====
// ----------------------------------------------------------------------------
// vrlb_pkg
// shared types and codes for the visible rectangle list builder
// ----------------------------------------------------------------------------
package vrlb_pkg;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_SUB   = 2'd1;
	localparam logic [1:0] REQ_EMIT  = 2'd2;

	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB_RD,
		ST_SUB_PIECE,
		ST_SUB_COPY,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;     // capture input item
		logic do_start;     // write own rect, count 1, clear overflow
		logic rd_cur;       // read current bank at rd index
		logic rd_idx_clr;
		logic rd_idx_inc;
		logic piece_eval;   // evaluate piece slot against read rect
		logic slot_clr;
		logic slot_inc;
		logic pass_clr;
		logic rd_pass;      // read pass buffer for reverse copy
		logic cp_inc;
		logic cp_wr;        // write copied entry to next bank
		logic swap;         // finish pass
		logic emit_out;     // drive a list result
		logic emit_empty;   // drive the empty result
	} vrlb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic rd_last;      // rd index is last list entry
		logic slot_last;    // piece slot is the final one for this rect
		logic cp_done;      // all pass entries copied
	} vrlb_sts_t;

endpackage

// ===== design/visible_rect_list_builder_core.sv =====
// ----------------------------------------------------------------------------
// visible_rect_list_builder_core
// builds the list of visible clip rectangles of a window
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. a start item loads
// the window's own rectangle as a one-entry list. a subtract item walks
// the listed rectangles with one store read and five piece slots per listed
// entry (keep, left, right, top, bottom), then copies the new list back in
// reverse at one entry a cycle. an emit item reads each listed entry and
// gives it as a result, or one empty result for an empty list, each on the
// result ports for a single cycle marked by valid; the receiver cannot hold
// results off and must take every result as it appears. busy falls in the
// cycle that carries the last result. the stores hold no valid bits: only
// entries below the list count are read.
`include "visible_rect_list_builder_core_defines.svh"

module visible_rect_list_builder_core #(
	parameter int MAX_RECTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	output logic               valid,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_h,
	output logic               last_piece,
	output logic               list_empty,
	output logic               overflowed
);

	vrlb_pkg::vrlb_cmd_t cmd;
	vrlb_pkg::vrlb_sts_t sts;

	// sequencer
	vrlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	// stores and piece maths
	vrlb_dp #(.MAX_RECTS(MAX_RECTS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.sts        (sts),
		.valid      (valid),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_w      (out_w),
		.out_h      (out_h),
		.last_piece (last_piece),
		.list_empty (list_empty),
		.overflowed (overflowed)
	);

	// a result is only ever produced while an item is in progress
	`VRLB_ASSERT_IMP(a_valid_busy, clk, arst_n, valid, $past(busy), "result without item")
	// an empty result is always the final one
	`VRLB_ASSERT_IMP(a_empty_last, clk, arst_n, valid && list_empty, last_piece, "empty not last")
	// after the final result the block is ready again
	`VRLB_ASSERT_IMP(a_last_idle, clk, arst_n, valid && last_piece, !busy, "busy after last")

endmodule

// ===== design/vrlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrlb_ctrl
// sequencer for start, subtract and emit items
// ----------------------------------------------------------------------------
module vrlb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          req_type,
	input  vrlb_pkg::vrlb_sts_t sts,
	output logic                busy,
	output vrlb_pkg::vrlb_cmd_t cmd
);

	vrlb_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrlb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		case (state_q)
			vrlb_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_req = 1'b1;
					case (req_type)
						vrlb_pkg::REQ_START: cmd.do_start = 1'b1;
						vrlb_pkg::REQ_SUB: begin
							if (!sts.cnt_zero) begin
								cmd.rd_idx_clr = 1'b1;
								cmd.pass_clr   = 1'b1;
								state_nxt      = vrlb_pkg::ST_SUB_RD;
							end
						end
						vrlb_pkg::REQ_EMIT: begin
							cmd.rd_idx_clr = 1'b1;
							state_nxt      = vrlb_pkg::ST_EMIT_RD;
						end
						default: ;
					endcase
				end
			end
			vrlb_pkg::ST_SUB_RD: begin
				cmd.rd_cur   = 1'b1;
				cmd.slot_clr = 1'b1;
				state_nxt    = vrlb_pkg::ST_SUB_PIECE;
			end
			vrlb_pkg::ST_SUB_PIECE: begin
				cmd.piece_eval = 1'b1;
				if (sts.slot_last) begin
					cmd.rd_idx_inc = 1'b1;
					if (sts.rd_last) begin
						cmd.rd_idx_clr = 1'b1;
						state_nxt      = vrlb_pkg::ST_SUB_COPY;
					end else begin
						state_nxt = vrlb_pkg::ST_SUB_RD;
					end
				end else begin
					cmd.slot_inc = 1'b1;
				end
			end
			vrlb_pkg::ST_SUB_COPY: begin
				// read pass buffer tail first, write previous read
				if (sts.cp_done) begin
					cmd.swap  = 1'b1;
					state_nxt = vrlb_pkg::ST_IDLE;
				end else begin
					cmd.rd_pass = 1'b1;
					cmd.cp_inc  = 1'b1;
				end
				cmd.cp_wr = 1'b1;
			end
			vrlb_pkg::ST_EMIT_RD: begin
				if (sts.cnt_zero) begin
					cmd.emit_empty = 1'b1;
					state_nxt      = vrlb_pkg::ST_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_nxt  = vrlb_pkg::ST_EMIT_OUT;
				end
			end
			vrlb_pkg::ST_EMIT_OUT: begin
				cmd.emit_out   = 1'b1;
				cmd.rd_idx_inc = 1'b1;
				if (sts.rd_last) begin
					state_nxt = vrlb_pkg::ST_IDLE;
				end else begin
					state_nxt = vrlb_pkg::ST_EMIT_RD;
				end
			end
			default: state_nxt = vrlb_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== design/vrlb_dp.sv =====
// ----------------------------------------------------------------------------
// vrlb_dp
// banked rectangle stores, pass buffer and piece generator
// ----------------------------------------------------------------------------
module vrlb_dp #(
	parameter int MAX_RECTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vrlb_pkg::vrlb_cmd_t cmd,
	input  logic signed [15:0]  rect_x,
	input  logic signed [15:0]  rect_y,
	input  logic signed [15:0]  rect_w,
	input  logic signed [15:0]  rect_h,
	output vrlb_pkg::vrlb_sts_t sts,
	output logic                valid,
	output logic signed [15:0]  out_x,
	output logic signed [15:0]  out_y,
	output logic signed [15:0]  out_w,
	output logic signed [15:0]  out_h,
	output logic                last_piece,
	output logic                list_empty,
	output logic                overflowed
);

	localparam int IW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_RECTS);

	vrlb_pkg::rect_t store_a [MAX_RECTS];
	vrlb_pkg::rect_t store_b [MAX_RECTS];
	vrlb_pkg::rect_t pass_mem [MAX_RECTS];

	vrlb_pkg::rect_t occ_q, own_q, pass_rd_q;
	logic            bank_q, ovf_q, cp_wr_ok_q;
	logic [CW-1:0]   cnt_q, rd_idx_q, pass_n_q, cp_q;
	logic [2:0]      slot_q;

	// overlap terms, all wrapping at 16 bits
	logic signed [15:0] r1, r2, b1, b2, ovx, ovy, ovw, ovh, ovr, ovb;
	logic               ov_pos, full, need_l, need_r, need_t, need_b;
	logic               pc_en;
	vrlb_pkg::rect_t    pc;

	always_comb begin
		r1  = own_q.x + own_q.w;
		r2  = occ_q.x + occ_q.w;
		b1  = own_q.y + own_q.h;
		b2  = occ_q.y + occ_q.h;
		ovx = (own_q.x > occ_q.x) ? own_q.x : occ_q.x;
		ovy = (own_q.y > occ_q.y) ? own_q.y : occ_q.y;
		ovw = ((r1 < r2) ? r1 : r2) - ovx;
		ovh = ((b1 < b2) ? b1 : b2) - ovy;
		ovr = ovx + ovw;
		ovb = ovy + ovh;
		ov_pos = (ovw > 16'sd0) && (ovh > 16'sd0);
		full   = (own_q.w == ovw) && (own_q.h == ovh);
		need_l = ovx != own_q.x;
		need_r = ovr != r1;
		need_t = ovy != own_q.y;
		need_b = ovb != b1;
		pc_en  = 1'b0;
		pc     = own_q;
		// slot 0 keep, 1 left, 2 right, 3 top, 4 bottom
		case (slot_q)
			3'd0: pc_en = !ov_pos;
			3'd1: begin
				pc_en = ov_pos && !full && need_l;
				pc.w  = ovx - own_q.x;
			end
			3'd2: begin
				pc_en = ov_pos && !full && need_r;
				pc.x  = ovr;
				pc.w  = r1 - ovr;
			end
			3'd3: begin
				pc_en = ov_pos && !full && need_t;
				pc.x  = ovx;
				pc.w  = ovw;
				pc.h  = ovy - own_q.y;
			end
			default: begin
				pc_en = ov_pos && !full && need_b;
				pc.x  = ovx;
				pc.y  = ovb;
				pc.w  = ovw;
				pc.h  = b1 - ovb;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			ovf_q      <= 1'b0;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			pass_n_q   <= '0;
			cp_q       <= '0;
			slot_q     <= '0;
			cp_wr_ok_q <= 1'b0;
			valid      <= 1'b0;
		end else begin
			valid <= cmd.emit_out || cmd.emit_empty;
			if (cmd.do_start) begin
				cnt_q <= CW'(1);
				ovf_q <= 1'b0;
			end
			if (cmd.rd_idx_clr) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_idx_inc) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.slot_clr) begin
				slot_q <= '0;
			end else if (cmd.slot_inc) begin
				slot_q <= slot_q + 1'b1;
			end
			if (cmd.pass_clr) begin
				pass_n_q <= '0;
				cp_q     <= '0;
			end else if (cmd.piece_eval && pc_en) begin
				if (pass_n_q == CAP) begin
					ovf_q <= 1'b1;
				end else begin
					pass_n_q <= pass_n_q + 1'b1;
				end
			end
			if (cmd.cp_inc) begin
				cp_q <= cp_q + 1'b1;
			end
			cp_wr_ok_q <= cmd.rd_pass;
			if (cmd.swap) begin
				bank_q <= !bank_q;
				cnt_q  <= pass_n_q;
			end
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			occ_q <= '{h: rect_h, w: rect_w, y: rect_y, x: rect_x};
		end
		if (cmd.do_start) begin
			if (bank_q) begin
				store_b[0] <= '{h: rect_h, w: rect_w, y: rect_y, x: rect_x};
			end else begin
				store_a[0] <= '{h: rect_h, w: rect_w, y: rect_y, x: rect_x};
			end
		end
		if (cmd.rd_cur) begin
			if (bank_q) begin
				own_q <= store_b[rd_idx_q[IW-1:0]];
			end else begin
				own_q <= store_a[rd_idx_q[IW-1:0]];
			end
		end
		if (cmd.piece_eval && pc_en && (pass_n_q != CAP)) begin
			pass_mem[pass_n_q[IW-1:0]] <= pc;
		end
		if (cmd.rd_pass) begin
			pass_rd_q <= pass_mem[IW'(pass_n_q - cp_q - 1'b1)];
		end
		if (cmd.cp_wr && cp_wr_ok_q) begin
			if (bank_q) begin
				store_a[IW'(cp_q - 1'b1)] <= pass_rd_q;
			end else begin
				store_b[IW'(cp_q - 1'b1)] <= pass_rd_q;
			end
		end
		if (cmd.emit_out) begin
			out_x      <= own_q.x;
			out_y      <= own_q.y;
			out_w      <= own_q.w;
			out_h      <= own_q.h;
			last_piece <= (rd_idx_q + 1'b1) == cnt_q;
			list_empty <= 1'b0;
			overflowed <= ovf_q;
		end else if (cmd.emit_empty) begin
			out_x      <= '0;
			out_y      <= '0;
			out_w      <= '0;
			out_h      <= '0;
			last_piece <= 1'b1;
			list_empty <= 1'b1;
			overflowed <= ovf_q;
		end
	end

	always_comb begin
		sts.cnt_zero  = cnt_q == '0;
		sts.rd_last   = (rd_idx_q + 1'b1) == cnt_q;
		sts.slot_last = slot_q == 3'd4;
		sts.cp_done   = cp_q == pass_n_q;
	end

endmodule

// ===== test/visible_rect_list_builder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// visible_rect_list_builder_core_test
// self-checking bench: drives start, subtract and emit items, predicts every
// emitted rectangle with a behavioural clip-list model and compares per field
// ----------------------------------------------------------------------------
module visible_rect_list_builder_core_test;

	localparam int MAXR = 32;
	localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, ignored by the block
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
	} req_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic               last;
		logic               empty;
		logic               ovf;
	} vis_rect_t;

	logic clk, arst_n, start, busy, valid;
	logic [1:0] req_type;
	logic signed [15:0] rect_x, rect_y, rect_w, rect_h;
	logic signed [15:0] out_x, out_y, out_w, out_h;
	logic last_piece, list_empty, overflowed;

	visible_rect_list_builder_core #(.MAX_RECTS(MAXR)) dut (.*);

	// pending items, expected results, error and progress counters
	req_item_t pending_items[$];
	vis_rect_t expected_rects[$];
	int        error_count = 0;
	int        accepted_items = 0;
	int        rects_checked = 0;
	int        max_list_seen = 0;
	int        send_idle_pct = 0;
	longint    cycle_count = 0;
	logic      accepted_q;

	// predictor state: the visible list, head first
	logic signed [15:0] vis_x[$], vis_y[$], vis_w[$], vis_h[$];
	logic               vis_ovf = 1'b0;
	// pieces of the current pass in production order
	logic signed [15:0] pc_x[$], pc_y[$], pc_w[$], pc_h[$];

	function automatic void produce_piece(logic signed [15:0] x, y, w, h);
		if (pc_x.size() >= MAXR) begin
			vis_ovf = 1'b1;
			return;
		end
		pc_x.push_back(x); pc_y.push_back(y); pc_w.push_back(w); pc_h.push_back(h);
	endfunction

	// subtract one occluder from one listed rectangle, all in 16-bit wrap
	function automatic void clip_one(logic signed [15:0] ox, oy, ow, oh,
			logic signed [15:0] cx, cy, cw, ch);
		logic signed [15:0] r1, r2, b1, b2, vx, vy, vw, vh;
		r1 = ox + ow; r2 = cx + cw;
		b1 = oy + oh; b2 = cy + ch;
		vx = (ox > cx) ? ox : cx;
		vy = (oy > cy) ? oy : cy;
		vw = ((r1 < r2) ? r1 : r2) - vx;
		vh = ((b1 < b2) ? b1 : b2) - vy;
		if (!(vw > 0 && vh > 0)) begin
			produce_piece(ox, oy, ow, oh);
			return;
		end
		if (ow == vw && oh == vh)
			return;
		if (vx != ox)
			produce_piece(ox, oy, vx - ox, oh);
		if (16'(vx + vw) != r1)
			produce_piece(vx + vw, oy, r1 - 16'(vx + vw), oh);
		if (vy != oy)
			produce_piece(vx, oy, vw, vy - oy);
		if (16'(vy + vh) != b1)
			produce_piece(vx, vy + vh, vw, b1 - 16'(vy + vh));
	endfunction

	// apply one accepted item to the predicted list, queue emitted rectangles
	function automatic void predict_visible(req_item_t it);
		vis_rect_t r;
		int n;
		case (it.kind)
			vrlb_pkg::REQ_START: begin
				vis_x = {it.x}; vis_y = {it.y}; vis_w = {it.w}; vis_h = {it.h};
				vis_ovf = 1'b0;
			end
			vrlb_pkg::REQ_SUB: begin
				if (vis_x.size() != 0) begin
					pc_x = {}; pc_y = {}; pc_w = {}; pc_h = {};
					foreach (vis_x[i])
						clip_one(vis_x[i], vis_y[i], vis_w[i], vis_h[i],
							it.x, it.y, it.w, it.h);
					vis_x = {}; vis_y = {}; vis_w = {}; vis_h = {};
					// prepending reverses production order
					for (n = pc_x.size() - 1; n >= 0; n--) begin
						vis_x.push_back(pc_x[n]); vis_y.push_back(pc_y[n]);
						vis_w.push_back(pc_w[n]); vis_h.push_back(pc_h[n]);
					end
					if (vis_x.size() > max_list_seen)
						max_list_seen = vis_x.size();
				end
			end
			vrlb_pkg::REQ_EMIT: begin
				if (vis_x.size() == 0) begin
					r = '0; r.last = 1'b1; r.empty = 1'b1; r.ovf = vis_ovf;
					expected_rects.push_back(r);
				end else
					foreach (vis_x[i]) begin
						r.x = vis_x[i]; r.y = vis_y[i]; r.w = vis_w[i]; r.h = vis_h[i];
						r.last = (i == vis_x.size() - 1); r.empty = 1'b0; r.ovf = vis_ovf;
						expected_rects.push_back(r);
					end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("mismatch on result %0d: %s got %0d expected %0d",
			rects_checked, what, got, want);
	endtask

	// clock and cycle guard
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("visible_rect_list_builder_core_test: errors");
			$finish;
		end
	end

	// driver: presents the head of the pending queue on the falling edge and
	// holds it until the rising edge that takes it
	always @(negedge clk) begin
		if (!arst_n) begin
			start    <= 1'b0;
			req_type <= vrlb_pkg::REQ_START;
			rect_x   <= '0;
			rect_y   <= '0;
			rect_w   <= '0;
			rect_h   <= '0;
		end else if (!start || accepted_q) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				start    <= 1'b1;
				req_type <= pending_items[0].kind;
				rect_x   <= pending_items[0].x;
				rect_y   <= pending_items[0].y;
				rect_w   <= pending_items[0].w;
				rect_h   <= pending_items[0].h;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// acceptance tracking at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
		end else begin
			accepted_q <= start && !busy;
			if (start && !busy) begin
				predict_visible(pending_items.pop_front());
				accepted_items <= accepted_items + 1;
			end
		end
	end

	// monitor: results live for one cycle, checked at the rising edge
	always @(posedge clk) begin
		vis_rect_t want;
		if (arst_n && valid) begin
			if (expected_rects.size() == 0) begin
				report_mismatch("unexpected result out_x", out_x, 0);
			end else begin
				want = expected_rects.pop_front();
				if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
				if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
				if (out_h !== want.h) report_mismatch("out_h", out_h, want.h);
				if (last_piece !== want.last)
					report_mismatch("last_piece", last_piece, want.last);
				if (list_empty !== want.empty)
					report_mismatch("list_empty", list_empty, want.empty);
				if (overflowed !== want.ovf)
					report_mismatch("overflowed", overflowed, want.ovf);
				rects_checked++;
			end
		end
	end

	function automatic req_item_t mk(logic [1:0] k, int x, y, w, h);
		req_item_t it;
		it.kind = k; it.x = 16'(x); it.y = 16'(y); it.w = 16'(w); it.h = 16'(h);
		return it;
	endfunction

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// small occluders around a 0..200 window, sometimes anywhere
	function automatic req_item_t rnd_occluder();
		if ($urandom_range(9) == 0)
			return mk(vrlb_pkg::REQ_SUB, rnd16(), rnd16(), rnd16(), rnd16());
		return mk(vrlb_pkg::REQ_SUB, $urandom_range(220) - 20, $urandom_range(220) - 20,
			$urandom_range(60), $urandom_range(60));
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_rects.size() != 0 || start)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		int phase, k, j, n_occ;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty list, ignored code, extremes, each piece direction,
		// no overlap, wrap-around, overflow and its clearing
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 1, 1, 1, 1));
		pending_items.push_back(mk(REQ_NONE, -1, -1, -1, -1));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_START, 0, 0, 100, 100));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 40, 40, 20, 20));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 500, 500, 10, 10));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 0, 0, 0, 50));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, -32768, -32768, 32767, 32767));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_START, 32767, -32768, 32767, -32768));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 32700, -32768, 100, 100));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_START, 30000, 30000, 5000, 5000));
		pending_items.push_back(mk(vrlb_pkg::REQ_SUB, 32000, 32000, 100, 100));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		// grid of holes drives the list past capacity
		pending_items.push_back(mk(vrlb_pkg::REQ_START, 0, 0, 1000, 1000));
		for (k = 0; k < 5; k++)
			for (j = 0; j < 5; j++)
				pending_items.push_back(mk(vrlb_pkg::REQ_SUB,
					100 + 180 * j, 100 + 180 * k, 30, 30));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		pending_items.push_back(mk(vrlb_pkg::REQ_START, 0, 0, 10, 10));
		pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
		wait_drained();

		// random: window, a run of occluders, emits, under four pacing phases
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 84 : (phase == 3) ? 34 : 0;
			for (k = 0; k < 6; k++) begin
				if ($urandom_range(7) == 0)
					pending_items.push_back(mk(vrlb_pkg::REQ_START,
						rnd16(), rnd16(), rnd16(), rnd16()));
				else
					pending_items.push_back(mk(vrlb_pkg::REQ_START, 0, 0, 200, 200));
				n_occ = $urandom_range(8, 3);
				for (j = 0; j < n_occ; j++) begin
					if ($urandom_range(5) == 0)
						pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, rnd16(), 0, 0, 0));
					else if ($urandom_range(40) == 0)
						pending_items.push_back(mk(REQ_NONE, rnd16(), rnd16(), rnd16(), rnd16()));
					else
						pending_items.push_back(rnd_occluder());
				end
				pending_items.push_back(mk(vrlb_pkg::REQ_EMIT, 0, 0, 0, 0));
			end
			wait_drained();
		end

		$display("%0d items accepted, %0d rectangles checked, longest list %0d",
			accepted_items, rects_checked, max_list_seen);
		if (error_count == 0)
			$display("visible_rect_list_builder_core_test: clean");
		else
			$display("visible_rect_list_builder_core_test: errors");
		$finish;
	end

endmodule
